// File: src/unpa_pkg.sv
// Shared types and constants for the uniform noise pixel adder.
// No dependencies; every other file of the block refers to this package by scoped names.
package unpa_pkg;

    localparam int unsigned PIX_W   = 8;
    localparam int unsigned SPAN_W  = 9;
    localparam int unsigned LCG_W   = 32;
    localparam int unsigned PROD_W  = LCG_W + SPAN_W;
    localparam int unsigned NOISE_W = 11;
    localparam int unsigned NUM_LANES = 3;

    localparam logic [LCG_W-1:0]  LCG_MUL    = 32'd1664525;
    localparam logic [LCG_W-1:0]  LCG_ADD    = 32'd1013904223;
    localparam logic [LCG_W-1:0]  LCG_MOD    = 32'hFFFF_FFFF;
    localparam logic [SPAN_W-1:0] SPAN_RESET = 9'd25;
    localparam logic [PIX_W-1:0]  PIX_MAX    = 8'd255;

    typedef logic [PIX_W-1:0]          t_chan;
    typedef logic signed [NOISE_W-1:0] t_noise;

    // One RGB pixel, lane order red, green, blue.
    typedef t_chan [NUM_LANES-1:0] t_pix;

    // Pipeline control shared between the top level and the stage modules.
    typedef struct packed {
        logic en;      // whole pipeline moves this cycle
        logic accept;  // a new request enters this cycle
    } t_pipe_ctl;

endpackage

// File: src/uniform_noise_pixel_adder.sv
// Top level of the uniform noise pixel adder: handshakes, pixel pipeline, lanes, output.
// Depends on unpa_pkg, unpa_lcg, unpa_noise and unpa_lane.
//
//  Channel   Signals                               Direction  Moves
//  --------  ------------------------------------  ---------  ---------------------------
//  input     i_in_valid, o_in_stall, i_*_in        in         one RGB pixel request
//  output    o_out_valid, i_out_stall, o_*_out     out        one noisy RGB pixel request
//  config    i_cfg_wr_en, i_cfg_wr_data            in         noise span, 9 bits
//
// One pixel request is taken every clock cycle while the output is not stalled. The four
// register stages are the generator step, the span multiply, the exact divide and
// centering, and the three-lane clamp into the output register.
// Reset is synchronous and active low: it empties the pipeline, sets the generator to zero
// and the span to 25. A stall on a valid output freezes every stage at once, and the input
// is stalled in the same cycle so no request is lost or repeated.
module uniform_noise_pixel_adder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [7:0]                  i_red_in,
    input  logic [7:0]                  i_green_in,
    input  logic [7:0]                  i_blue_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [7:0]                  o_red_out,
    output logic [7:0]                  o_green_out,
    output logic [7:0]                  o_blue_out,
    input  logic                        i_cfg_wr_en,
    input  logic [unpa_pkg::SPAN_W-1:0] i_cfg_wr_data
);

    unpa_pkg::t_pipe_ctl w_ctl;

    logic [unpa_pkg::SPAN_W-1:0] r_span;

    // Valid bits of the stages: after the generator step, after the multiply,
    // after the noise stage, and at the output register.
    logic r_s1_valid;
    logic r_s2_valid;
    logic r_s3_valid;
    logic r_out_valid;

    unpa_pkg::t_pix r_s1_pix;
    unpa_pkg::t_pix r_s2_pix;
    unpa_pkg::t_pix r_s3_pix;
    unpa_pkg::t_pix r_out_pix;
    unpa_pkg::t_pix n_out_pix;
    unpa_pkg::t_pix w_in_pix;

    logic [unpa_pkg::LCG_W-1:0] w_value;
    unpa_pkg::t_noise           w_noise;

    // The pipeline moves unless a finished pixel is waiting on a stalled output.
    assign w_ctl.en     = !(r_out_valid && i_out_stall);
    assign w_ctl.accept = w_ctl.en && i_in_valid;
    assign o_in_stall   = !w_ctl.en;

    assign w_in_pix[0] = i_red_in;
    assign w_in_pix[1] = i_green_in;
    assign w_in_pix[2] = i_blue_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span <= unpa_pkg::SPAN_RESET;
        end else if (i_cfg_wr_en) begin
            r_span <= i_cfg_wr_data;
        end
    end

    // The generator register holds the value for the pixel in stage one until the next request
    // is accepted, which is never before the edge on which that pixel moves on.
    unpa_lcg u_lcg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_value (w_value)
    );

    unpa_noise u_noise (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_value (w_value),
        .i_span  (r_span),
        .o_noise (w_noise)
    );

    // Three lanes apply the same noise to red, green and blue side by side.
    for (genvar g = 0; g < unpa_pkg::NUM_LANES; g++) begin : g_lane
        unpa_lane u_lane (
            .i_chan  (r_s3_pix[g]),
            .i_noise (w_noise),
            .o_chan  (n_out_pix[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_ctl.en) begin
            r_s1_valid  <= i_in_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    // The merge stage gathers the lane results into one output pixel register.
    always_ff @(posedge i_clk) begin
        if (w_ctl.en) begin
            r_s1_pix  <= w_in_pix;
            r_s2_pix  <= r_s1_pix;
            r_s3_pix  <= r_s2_pix;
            r_out_pix <= n_out_pix;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_red_out   = r_out_pix[0];
    assign o_green_out = r_out_pix[1];
    assign o_blue_out  = r_out_pix[2];

endmodule

// File: src/unpa_lcg.sv
// Generator state of the uniform noise pixel adder: one step per accepted request.
// Depends on unpa_pkg.
module unpa_lcg (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  unpa_pkg::t_pipe_ctl      i_ctl,
    output logic [unpa_pkg::LCG_W-1:0] o_value
);

    logic [unpa_pkg::LCG_W-1:0] r_lcg;
    logic [unpa_pkg::LCG_W-1:0] n_lcg;
    logic [unpa_pkg::LCG_W-1:0] w_step;

    // Multiply-add modulo 2^32, then fold an all-ones result to zero.
    assign w_step = r_lcg * unpa_pkg::LCG_MUL + unpa_pkg::LCG_ADD;
    assign n_lcg  = (w_step == unpa_pkg::LCG_MOD) ? '0 : w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcg <= '0;
        end else if (i_ctl.accept) begin
            r_lcg <= n_lcg;
        end
    end

    assign o_value = r_lcg;

endmodule

// File: src/unpa_noise.sv
// Noise stages: scales the generator value by the span, then divides exactly by 2^32-1
// and centers the result. Depends on unpa_pkg.
module unpa_noise (
    input  logic                        i_clk,
    input  unpa_pkg::t_pipe_ctl         i_ctl,
    input  logic [unpa_pkg::LCG_W-1:0]  i_value,
    input  logic [unpa_pkg::SPAN_W-1:0] i_span,
    output unpa_pkg::t_noise            o_noise
);

    logic [unpa_pkg::PROD_W-1:0] r_prod;
    unpa_pkg::t_noise            r_noise;
    unpa_pkg::t_noise            n_noise;

    logic [unpa_pkg::SPAN_W-1:0]  w_hi;
    logic [unpa_pkg::LCG_W:0]     w_sum;
    logic                         w_wrap;
    logic                         w_rem_nz;
    logic [unpa_pkg::SPAN_W:0]    w_floor;
    logic [unpa_pkg::SPAN_W:0]    w_ceil;
    logic [unpa_pkg::SPAN_W-2:0]  w_half;
    logic [unpa_pkg::SPAN_W:0]    w_sel;

    // Since 2^32 is one more than the divisor, the product is hi*(2^32-1) + (hi + lo), and
    // hi + lo stays below twice the divisor: one compare gives quotient and remainder.
    assign w_hi     = r_prod[unpa_pkg::PROD_W-1:unpa_pkg::LCG_W];
    assign w_sum    = {1'b0, r_prod[unpa_pkg::LCG_W-1:0]}
                    + {{(unpa_pkg::LCG_W+1-unpa_pkg::SPAN_W){1'b0}}, w_hi};
    assign w_wrap   = (w_sum >= {1'b0, unpa_pkg::LCG_MOD});
    assign w_rem_nz = w_wrap ? (w_sum != {1'b0, unpa_pkg::LCG_MOD}) : (w_sum != '0);
    assign w_floor  = {1'b0, w_hi} + {{unpa_pkg::SPAN_W{1'b0}}, w_wrap};
    assign w_ceil   = w_floor + {{unpa_pkg::SPAN_W{1'b0}}, w_rem_nz};
    assign w_half   = i_span[unpa_pkg::SPAN_W-1:1];

    // Round toward zero: the floor above the center, the ceiling below it.
    assign w_sel   = (w_floor >= {2'b00, w_half}) ? w_floor : w_ceil;
    assign n_noise = $signed({1'b0, w_sel}) - $signed({3'b000, w_half});

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_prod  <= {{unpa_pkg::SPAN_W{1'b0}}, i_value}
                     * {{unpa_pkg::LCG_W{1'b0}}, i_span};
            r_noise <= n_noise;
        end
    end

    assign o_noise = r_noise;

endmodule

// File: src/unpa_lane.sv
// One color lane: adds the noise to a channel and clamps to the pixel range.
// Depends on unpa_pkg.
module unpa_lane (
    input  unpa_pkg::t_chan  i_chan,
    input  unpa_pkg::t_noise i_noise,
    output unpa_pkg::t_chan  o_chan
);

    logic signed [unpa_pkg::NOISE_W:0] w_sum;

    assign w_sum = $signed({{(unpa_pkg::NOISE_W+1-unpa_pkg::PIX_W){1'b0}}, i_chan})
                 + $signed({i_noise[unpa_pkg::NOISE_W-1], i_noise});

    always_comb begin
        priority if (w_sum < 0) begin
            o_chan = '0;
        end else if (w_sum > $signed({{(unpa_pkg::NOISE_W+1-unpa_pkg::PIX_W){1'b0}},
                                      unpa_pkg::PIX_MAX})) begin
            o_chan = unpa_pkg::PIX_MAX;
        end else begin
            o_chan = w_sum[unpa_pkg::PIX_W-1:0];
        end
    end

endmodule
